@@ hdl/text_console_cursor_scroll_unit_defines.svh @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit_defines.svh
// assertion macros for the text console cursor and scroll unit
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TCSU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tcsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsu_pkg
// shared constants, payload types and control structs for the console unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcsu_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int CELL_W     = 16;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // character and attribute codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;
   localparam logic [CELL_W-1:0] BLANK_CELL   = {RESET_COLOR, SPACE_CODE};

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // request transaction
   typedef struct packed {
      op_type             op;
      logic [CHAR_W-1:0]  char_code;
      logic [ROW_W-1:0]   cell_row;
      logic [COL_W-1:0]   cell_col;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [CELL_W-1:0]  cell_data;
      logic [ROW_W-1:0]   cursor_row;
      logic [COL_W-1:0]   cursor_col;
      logic               scrolled;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic rd_latch;
      logic clr_step;
      logic init_step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_read;
      logic need_clear;
      logic clr_last;
      logic init_last;
   } sts_type;

endpackage

`default_nettype wire

@@ hdl/tcsu_datapath.sv @@
// ----------------------------------------------------------------------------
// tcsu_datapath
// screen store, cursor, scroll offset and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcsu_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tcsu_pkg::cmd_type cmd,
   output tcsu_pkg::sts_type sts,
   input  tcsu_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [tcsu_pkg::CHAR_W-1:0] csr_data,
   output tcsu_pkg::rsp_type rsp_data
);

   localparam int RSUM_W = tcsu_pkg::ROW_W + 1;
   localparam int CINC_W = tcsu_pkg::COL_W + 1;

   // logical row to physical row of the circular store
   function automatic logic [tcsu_pkg::ROW_W-1:0] phys_row(
      input logic [tcsu_pkg::ROW_W-1:0] r,
      input logic [tcsu_pkg::ROW_W-1:0] t
   );
      logic [RSUM_W-1:0] sum;
      sum = {1'b0, r} + {1'b0, t};
      if (sum >= RSUM_W'(tcsu_pkg::ROWS)) begin
         sum = sum - RSUM_W'(tcsu_pkg::ROWS);
      end
      return sum[tcsu_pkg::ROW_W-1:0];
   endfunction

   // physical row and column to store address
   function automatic logic [tcsu_pkg::ADDR_W-1:0] cell_addr(
      input logic [tcsu_pkg::ROW_W-1:0] r,
      input logic [tcsu_pkg::COL_W-1:0] c
   );
      return tcsu_pkg::ADDR_W'(32'(r) * tcsu_pkg::COLUMNS + 32'(c));
   endfunction

   logic [tcsu_pkg::CELL_W-1:0] screen_mem [tcsu_pkg::CELL_COUNT];

   tcsu_pkg::req_type             req_q_ff, req_q_in;
   logic [tcsu_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tcsu_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcsu_pkg::ROW_W-1:0]    top_ff, top_in;
   logic [tcsu_pkg::CHAR_W-1:0]   color_ff, color_in;
   logic [tcsu_pkg::ROW_W-1:0]    clr_row_ff, clr_row_in;
   logic [tcsu_pkg::COL_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [tcsu_pkg::ADDR_W-1:0]   init_cnt_ff, init_cnt_in;
   logic [tcsu_pkg::CELL_W-1:0]   res_data_ff, res_data_in;
   logic                          res_scr_ff, res_scr_in;
   tcsu_pkg::rsp_type             rsp_ff, rsp_in;
   logic [tcsu_pkg::CELL_W-1:0]   rd_data_ff;

   logic                          is_read;
   logic                          is_nl;
   logic                          read_ok;
   logic [CINC_W-1:0]             col_inc;
   logic                          line_end;
   logic                          at_bottom;
   logic                          need_row;

   logic                          mem_we;
   logic [tcsu_pkg::ADDR_W-1:0]   mem_waddr;
   logic [tcsu_pkg::CELL_W-1:0]   mem_wdata;
   logic                          mem_re;
   logic [tcsu_pkg::ADDR_W-1:0]   mem_raddr;

   // decode of the held transaction
   always_comb begin
      is_read   = (req_q_ff.op == tcsu_pkg::OP_READ);
      is_nl     = (req_q_ff.char_code == tcsu_pkg::NEWLINE_CODE);
      read_ok   = (32'(req_q_ff.cell_row) < tcsu_pkg::ROWS) &&
                  (32'(req_q_ff.cell_col) < tcsu_pkg::COLUMNS);
      col_inc   = {1'b0, col_ff} + CINC_W'(1);
      line_end  = (col_inc >= CINC_W'(tcsu_pkg::COLUMNS));
      at_bottom = (row_ff == tcsu_pkg::ROW_W'(tcsu_pkg::ROWS - 1));
      need_row  = !is_read && (is_nl || line_end);
   end

   // status to the controller
   always_comb begin
      sts.need_read  = is_read && read_ok;
      sts.need_clear = need_row && at_bottom;
      sts.clr_last   = (clr_cnt_ff == tcsu_pkg::COL_W'(tcsu_pkg::COLUMNS - 1));
      sts.init_last  = (init_cnt_ff == tcsu_pkg::ADDR_W'(tcsu_pkg::CELL_COUNT - 1));
   end

   // next state of cursor, offset and result registers
   always_comb begin
      req_q_in    = req_q_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      top_in      = top_ff;
      color_in    = color_ff;
      clr_row_in  = clr_row_ff;
      clr_cnt_in  = clr_cnt_ff;
      init_cnt_in = init_cnt_ff;
      res_data_in = res_data_ff;
      res_scr_in  = res_scr_ff;
      rsp_in      = rsp_ff;

      if (cmd.capture) begin
         req_q_in = req_data;
      end
      if (csr_we) begin
         color_in = csr_data;
      end
      if (cmd.exec) begin
         res_data_in = '0;
         res_scr_in  = sts.need_clear;
         clr_cnt_in  = '0;
         // the old top row becomes the new bottom row
         clr_row_in  = top_ff;
         if (need_row) begin
            col_in = '0;
            if (at_bottom) begin
               if (top_ff == tcsu_pkg::ROW_W'(tcsu_pkg::ROWS - 1)) begin
                  top_in = '0;
               end else begin
                  top_in = top_ff + tcsu_pkg::ROW_W'(1);
               end
            end else begin
               row_in = row_ff + tcsu_pkg::ROW_W'(1);
            end
         end else if (!is_read) begin
            col_in = col_inc[tcsu_pkg::COL_W-1:0];
         end
      end
      if (cmd.rd_latch) begin
         res_data_in = rd_data_ff;
      end
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + tcsu_pkg::COL_W'(1);
      end
      if (cmd.init_step) begin
         init_cnt_in = init_cnt_ff + tcsu_pkg::ADDR_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_in.cell_data  = res_data_ff;
         rsp_in.cursor_row = row_ff;
         rsp_in.cursor_col = col_ff;
         rsp_in.scrolled   = res_scr_ff;
      end
   end

   // store write and read port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      if (cmd.init_step) begin
         mem_we    = 1'b1;
         mem_waddr = init_cnt_ff;
         mem_wdata = tcsu_pkg::BLANK_CELL;
      end else if (cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr(clr_row_ff, clr_cnt_ff);
         mem_wdata = '0;
      end else if (cmd.exec && !is_read && !is_nl) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr(phys_row(row_ff, top_ff), col_ff);
         mem_wdata = {color_ff, req_q_ff.char_code};
      end
      mem_re    = cmd.exec && sts.need_read;
      mem_raddr = cell_addr(phys_row(req_q_ff.cell_row, top_ff), req_q_ff.cell_col);
   end

   // screen store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         top_ff      <= '0;
         color_ff    <= tcsu_pkg::RESET_COLOR;
         init_cnt_ff <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         top_ff      <= top_in;
         color_ff    <= color_in;
         init_cnt_ff <= init_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_q_ff    <= req_q_in;
      clr_row_ff  <= clr_row_in;
      clr_cnt_ff  <= clr_cnt_in;
      res_data_ff <= res_data_in;
      res_scr_ff  <= res_scr_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/tcsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcsu_ctrl
// sequencer for store clearing, transaction execution and response hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcsu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcsu_pkg::cmd_type cmd,
   input  tcsu_pkg::sts_type sts
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_CLEAR  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // commands decoded from the state
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.capture   = req_valid && req_ready;
      cmd.exec      = (state_ff == ST_EXEC);
      cmd.rd_latch  = (state_ff == ST_READ);
      cmd.clr_step  = (state_ff == ST_CLEAR);
      cmd.init_step = (state_ff == ST_INIT);
      cmd.load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // state transitions
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_read) begin
               state_in = ST_READ;
            end else if (sts.need_clear) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            if (sts.clr_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/text_console_cursor_scroll_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// character-cell text console with cursor, line wrap and upward scrolling
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data (tcsu_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data (tcsu_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready    csr_data (text colour)
//
// a character write reaches the response register via the exec and finish states,
// a cell read also via the read state (one registered store read), a scroll adds
// the clear state for clearing the new bottom row through the single store write port.
// scrolling moves a row offset; no cells are copied.
// after reset the store is filled with blanks, no requests
// are taken meanwhile. a new request is taken while a response still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_scroll_unit_defines.svh"

module text_console_cursor_scroll_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcsu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcsu_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [tcsu_pkg::CHAR_W-1:0] csr_data
);

   tcsu_pkg::cmd_type cmd;
   tcsu_pkg::sts_type sts;
   logic              csr_we;
   logic [3:0]        step_vec;
   logic              scroll_out;
   logic              at_home;

   // colour register always writable
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   tcsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcsu_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

   // assertions
   assign step_vec   = {cmd.init_step, cmd.clr_step, cmd.exec, cmd.rd_latch};
   assign scroll_out = rsp_valid && rsp_data.scrolled;
   assign at_home    = (rsp_data.cursor_row == tcsu_pkg::ROW_W'(tcsu_pkg::ROWS - 1)) &&
                       (rsp_data.cursor_col == '0);

   `TCSU_ASSERT_SAME(a_one_step, 1'b1, $onehot0(step_vec), "more than one datapath step active")
   `TCSU_ASSERT_NEXT(a_accept_blocks, req_valid && req_ready, !req_ready, "request taken while busy")
   `TCSU_ASSERT_NEXT(a_load_shows, cmd.load_rsp, rsp_valid, "loaded response not presented")
   `TCSU_ASSERT_SAME(a_scroll_cursor, scroll_out, at_home, "scroll not at bottom row start")

endmodule

`default_nettype wire
